FILE: hw/rtl/ehc_pkg.sv
// Shared types, constants and colour stops for the error heat-map colouriser.
package ehc_pkg;

    localparam int PIXELS_DEF        = 65536;
    localparam int FRACTION_BITS_DEF = 10;
    localparam int SAMPLE_W          = 16;
    localparam int INDEX_W           = 16;
    localparam int CHAN_W            = 8;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [INDEX_W-1:0]    pixel_index;
        logic [SAMPLE_W-1:0]   error_value;
        logic                  first_sample;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_norm_sts;

    // colour stop, bit 2 red, bit 1 green, bit 0 blue
    typedef logic [2:0] t_rgb;

    localparam t_rgb STOP_RGB [0:4] = '{
        3'b001,     // blue
        3'b011,     // cyan
        3'b010,     // green
        3'b110,     // yellow
        3'b100      // red
    };

endpackage

FILE: hw/rtl/ehc_store.sv
// Sample store: single-port-write, registered-read memory of error samples.
module ehc_store #(
    parameter int PIXELS = ehc_pkg::PIXELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(PIXELS)-1:0]     i_wr_addr,
    input  logic [ehc_pkg::SAMPLE_W-1:0]  i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(PIXELS)-1:0]     i_rd_addr,
    output logic [ehc_pkg::SAMPLE_W-1:0]  o_rd_data
);

    logic [ehc_pkg::SAMPLE_W-1:0] r_mem [PIXELS];
    logic [ehc_pkg::SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/ehc_norm.sv
// Normaliser: t = (e - min) / range, restoring division one quotient bit per cycle.
module ehc_norm #(
    parameter int FRACTION_BITS = ehc_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ehc_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [ehc_pkg::SAMPLE_W-1:0]  i_min,
    input  logic [ehc_pkg::SAMPLE_W-1:0]  i_max,
    output ehc_pkg::t_norm_sts            o_sts,
    output logic [FRACTION_BITS:0]        o_t
);

    localparam int SW    = ehc_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic [SW-1:0]            range_w;
    logic [SW-1:0]            diff;
    logic                     below;
    logic                     sat;
    logic [SW:0]              rem2;
    logic                     ge;
    logic [SW-1:0]            rem_next;

    logic                     r_busy;
    logic                     r_done;
    logic                     r_full;
    logic [SW-1:0]            r_rem;
    logic [SW-1:0]            r_div;
    logic [FRACTION_BITS-1:0] r_quo;
    logic [CNT_W-1:0]         r_cnt;

    always_comb begin
        range_w  = (i_max > i_min) ? (i_max - i_min) : SW'(1);
        below    = i_sample < i_min;
        diff     = i_sample - i_min;
        sat      = diff >= range_w;
        // remainder stays below the divisor, so doubling fits one extra bit
        rem2     = {r_rem, 1'b0};
        ge       = rem2 >= {1'b0, r_div};
        rem_next = ge ? SW'(rem2 - {1'b0, r_div}) : rem2[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= !(below || sat);
            r_done <= below || sat;
        end else if (r_busy && r_cnt == CNT_W'(1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= diff;
            r_div  <= range_w;
            r_quo  <= '0;
            r_full <= sat && !below;
            r_cnt  <= CNT_W'(FRACTION_BITS);
        end else if (r_busy) begin
            r_rem  <= rem_next;
            r_quo  <= {r_quo[FRACTION_BITS-2:0], ge};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_t = r_full ? (FRACTION_BITS+1)'(1) << FRACTION_BITS : {1'b0, r_quo};

endmodule

FILE: hw/rtl/ehc_color.sv
// Colour map: five-stop blue-cyan-green-yellow-red interpolation of t into 8-bit RGB.
module ehc_color #(
    parameter int FRACTION_BITS = ehc_pkg::FRACTION_BITS_DEF
) (
    input  logic [FRACTION_BITS:0] i_t,
    output ehc_pkg::t_out_beat     o_rgb
);

    localparam int FB = FRACTION_BITS;

    function automatic logic [7:0] to_byte(input logic [FB:0] x);
        logic [FB+8:0] sh;
        logic [8:0]    v;
        sh = {x, 8'h00};
        v  = sh[FB+8:FB];
        return (v > 9'd255) ? 8'hFF : v[7:0];
    endfunction

    logic [FB+2:0] s;
    logic [2:0]    c_raw;
    logic [1:0]    c;
    logic [FB+2:0] w_full;
    logic [FB:0]   w;
    logic [FB:0]   w_inv;
    logic [7:0]    rise;
    logic [7:0]    fall;
    ehc_pkg::t_rgb from_rgb;
    ehc_pkg::t_rgb to_rgb;
    logic [7:0]    chan [3];

    always_comb begin
        s        = {i_t, 2'b00};
        c_raw    = s[FB+2:FB];
        c        = (c_raw > 3'd3) ? 2'd3 : c_raw[1:0];
        w_full   = s - (FB+3)'({c, {FB{1'b0}}});
        w        = w_full[FB:0];
        w_inv    = ((FB+1)'(1) << FB) - w;
        rise     = to_byte(w);
        fall     = to_byte(w_inv);
        from_rgb = ehc_pkg::STOP_RGB[3'(c)];
        to_rgb   = ehc_pkg::STOP_RGB[3'(c) + 3'd1];
        for (int ch = 0; ch < 3; ch++) begin
            if (from_rgb[ch] == to_rgb[ch]) begin
                chan[ch] = from_rgb[ch] ? 8'hFF : 8'h00;
            end else if (to_rgb[ch]) begin
                chan[ch] = rise;
            end else begin
                chan[ch] = fall;
            end
        end
        o_rgb.red   = chan[2];
        o_rgb.green = chan[1];
        o_rgb.blue  = chan[0];
    end

endmodule

FILE: hw/rtl/error_heatmap_colorizer.sv
// Load beats may follow back to back; each in-range load writes the sample store.
// A read beat is taken in IDLE, where the memory read is registered; FETCH starts the divider,
// DIV waits for the divider iterations to finish, and OUT registers the colour result.
// A sample below min or at or above min + range skips the divider iterations.
// Input stalls until the result is registered, so no new beat is taken while a read is in
// progress, and the stall lasts longer while the result beat is stalled. Reset: min all ones, max zero.
module error_heatmap_colorizer #(
    parameter int PIXELS        = ehc_pkg::PIXELS_DEF,
    parameter int FRACTION_BITS = ehc_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ehc_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ehc_pkg::t_out_beat o_out_beat
);

    localparam int ADDR_W = $clog2(PIXELS);
    localparam int SW     = ehc_pkg::SAMPLE_W;
    localparam int IW     = ehc_pkg::INDEX_W;

    ehc_pkg::t_state    r_state;
    ehc_pkg::t_state    n_state;
    logic [SW-1:0]      r_min;
    logic [SW-1:0]      r_max;
    logic               r_out_valid;
    ehc_pkg::t_out_beat r_out_beat;

    logic               in_acc;
    logic               in_range;
    logic               load_acc;
    logic               read_acc;
    logic [ADDR_W+IW-1:0] idx_ext;
    logic [ADDR_W-1:0]  addr;
    logic [SW-1:0]      rd_data;
    logic               norm_start;
    logic               out_free;
    logic               out_load;
    ehc_pkg::t_norm_sts norm_sts;
    logic [FRACTION_BITS:0] t_val;
    ehc_pkg::t_out_beat rgb;

    always_comb begin
        in_acc   = i_in_valid && !o_in_stall;
        in_range = 32'(i_in_beat.pixel_index) < 32'(PIXELS);
        load_acc = in_acc && in_range && i_in_beat.action == ehc_pkg::ACT_LOAD;
        read_acc = in_acc && in_range && i_in_beat.action == ehc_pkg::ACT_READ;
        idx_ext  = (ADDR_W+IW)'(i_in_beat.pixel_index);
        addr     = idx_ext[ADDR_W-1:0];
        out_free = !r_out_valid || !i_out_stall;
    end

    ehc_store #(
        .PIXELS(PIXELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (load_acc),
        .i_wr_addr (addr),
        .i_wr_data (i_in_beat.error_value),
        .i_rd_en   (read_acc),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    ehc_norm #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (norm_start),
        .i_sample (rd_data),
        .i_min    (r_min),
        .i_max    (r_max),
        .o_sts    (norm_sts),
        .o_t      (t_val)
    );

    ehc_color #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_color (
        .i_t   (t_val),
        .o_rgb (rgb)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ehc_pkg::ST_IDLE:  if (read_acc) n_state = ehc_pkg::ST_FETCH;
            ehc_pkg::ST_FETCH: n_state = ehc_pkg::ST_DIV;
            ehc_pkg::ST_DIV:   if (norm_sts.done) n_state = ehc_pkg::ST_OUT;
            ehc_pkg::ST_OUT:   if (out_free) n_state = ehc_pkg::ST_IDLE;
            default:           n_state = ehc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        norm_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ehc_pkg::ST_IDLE:  o_in_stall = 1'b0;
            ehc_pkg::ST_FETCH: norm_start = 1'b1;
            ehc_pkg::ST_DIV:   o_in_stall = 1'b1;
            ehc_pkg::ST_OUT:   out_load   = out_free;
            default:           o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ehc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // running min/max; a first sample restarts tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
        end else if (load_acc) begin
            if (i_in_beat.first_sample) begin
                r_min <= i_in_beat.error_value;
                r_max <= i_in_beat.error_value;
            end else begin
                if (i_in_beat.error_value < r_min) r_min <= i_in_beat.error_value;
                if (i_in_beat.error_value > r_max) r_max <= i_in_beat.error_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_beat <= rgb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

FILE: hw/rtl/ehc_chk.sv
// Port-level checker for the heat-map colouriser, bound to the top level.
module ehc_chk #(
    parameter int PIXELS = ehc_pkg::PIXELS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ehc_pkg::t_in_beat  i_in_beat,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ehc_pkg::t_out_beat o_out_beat
);

    logic in_acc;
    logic in_range;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_range = 32'(i_in_beat.pixel_index) < 32'(PIXELS);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed or dropped");

    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_beat.action == ehc_pkg::ACT_LOAD |=> !o_in_stall)
        else $error("load beat stalled the next input");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_range && i_in_beat.action == ehc_pkg::ACT_READ |=> o_in_stall)
        else $error("input not stalled while a read is in progress");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat appeared without a read in progress");

endmodule

bind error_heatmap_colorizer ehc_chk #(.PIXELS(PIXELS)) u_ehc_chk (.*);
